// ----- design/mouse_event_report_accumulator_assert.svh -----
// assertion macros for the mouse event report accumulator
// no dependencies; included by the top level before its module header
`ifndef MOUSE_EVENT_REPORT_ACCUMULATOR_ASSERT_SVH
`define MOUSE_EVENT_REPORT_ACCUMULATOR_ASSERT_SVH

// same-cycle implication under clock and active-low reset
`define MERA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mera assertion failed");

// next-cycle implication under clock and active-low reset
`define MERA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mera assertion failed");

`endif

// ----- design/mera_pkg.sv -----
// shared constants and helpers for the mouse event report accumulator
// no dependencies; used by mouse_event_report_accumulator
package mera_pkg;

	// event types
	localparam logic [15:0] EV_TYPE_SYNC = 16'h0000;
	localparam logic [15:0] EV_TYPE_KEY  = 16'h0001;
	localparam logic [15:0] EV_TYPE_REL  = 16'h0002;

	// event codes
	localparam logic [15:0] SYNC_CODE_REPORT     = 16'h0000;
	localparam logic [15:0] REL_CODE_X           = 16'h0000;
	localparam logic [15:0] REL_CODE_Y           = 16'h0001;
	localparam logic [15:0] REL_CODE_WHEEL       = 16'h0008;
	localparam logic [15:0] REL_CODE_WHEEL_HIRES = 16'h000b;
	localparam logic [15:0] KEY_CODE_LEFT        = 16'h0110;
	localparam logic [15:0] KEY_CODE_RIGHT       = 16'h0111;
	localparam logic [15:0] KEY_CODE_MIDDLE      = 16'h0112;

	// button mask bits
	localparam logic [2:0] MASK_BIT_LEFT   = 3'h1;
	localparam logic [2:0] MASK_BIT_RIGHT  = 3'h2;
	localparam logic [2:0] MASK_BIT_MIDDLE = 3'h4;

	// high-res units per wheel detent, range 1 to 65535
	localparam int unsigned UNITS_PER_DETENT = 120;
	localparam logic [31:0] DETENT_UNITS = 32'(UNITS_PER_DETENT);

	// exact reciprocal for 32-bit magnitudes: q = (n * magic) >> shift
	localparam int unsigned DETENT_LOG2  = $clog2(UNITS_PER_DETENT);
	localparam int unsigned DETENT_SHIFT = 32 + DETENT_LOG2;
	localparam int unsigned DETENT_PROD_W = DETENT_SHIFT + 33;
	localparam logic [32:0] DETENT_MAGIC = 33'(((64'd1 << DETENT_SHIFT)
		+ 64'(UNITS_PER_DETENT) - 64'd1) / 64'(UNITS_PER_DETENT));

	typedef logic signed [15:0] acc16_t;
	typedef logic signed [31:0] acc32_t;

	// saturating add of a 33-bit signed value onto a 16-bit accumulator
	function automatic acc16_t sat_add16(acc16_t acc, logic signed [32:0] val);
		logic signed [33:0] sum;
		sum = 34'(acc) + 34'(val);
		if (sum > 34'sd32767) begin
			return 16'sh7fff;
		end else if (sum < -34'sd32768) begin
			return 16'sh8000;
		end
		return sum[15:0];
	endfunction

	// saturating 32-bit signed add
	function automatic acc32_t sat_add32(acc32_t acc, acc32_t val);
		logic signed [32:0] sum;
		sum = 33'(acc) + 33'(val);
		if (sum[32] != sum[31]) begin
			return sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		return sum[31:0];
	endfunction

endpackage

// ----- design/mouse_event_report_accumulator.sv -----
// mouse event report accumulator: input events in, one result per event out
// depends on mera_pkg and mouse_event_report_accumulator_assert.svh
//
// usage
//   event channel: event_valid / event_stall with event_type, event_code and
//   event_value; an item is taken at a clock edge with valid high, stall low
//   result channel: result_valid / result_stall with report_valid, buttons,
//   buttons_changed, delta_x, delta_y and wheel_steps; exactly one result
//   item for every event item, in order
//   path: an accepted item is held in the input register, then in the result
//   register, which drives the result port
//   throughput: one item per cycle while the result is not stalled; the input
//   register, state update and result register all advance together, and the
//   wheel detent divide is a single 32 x 33 reciprocal multiply in that step
//   stall: a stalled result holds; the input register keeps its item and
//   event_stall rises only once the input register is full behind it
//   reset: arst_n low clears the button mask, the x, y and wheel
//   accumulators, the high-res remainder, the dirty flag and both valids
`include "mouse_event_report_accumulator_assert.svh"

module mouse_event_report_accumulator (
	input  logic                clk,
	input  logic                arst_n,
	// event channel
	input  logic                event_valid,
	output logic                event_stall,
	input  logic [15:0]         event_type,
	input  logic [15:0]         event_code,
	input  logic signed [31:0]  event_value,
	// result channel
	output logic                result_valid,
	input  logic                result_stall,
	output logic                report_valid,
	output logic [2:0]          buttons,
	output logic                buttons_changed,
	output logic signed [15:0]  delta_x,
	output logic signed [15:0]  delta_y,
	output logic signed [15:0]  wheel_steps
);

	// input register
	logic                valid_s1;
	logic [15:0]         type_s1;
	logic [15:0]         code_s1;
	logic signed [31:0]  value_s1;

	// block state
	logic [2:0]          button_mask_q;
	mera_pkg::acc16_t    accum_x_q;
	mera_pkg::acc16_t    accum_y_q;
	mera_pkg::acc16_t    accum_wheel_q;
	mera_pkg::acc32_t    hires_rem_q;
	logic                dirty_q;

	// result register
	logic                result_valid_q;
	logic                report_valid_q;
	logic [2:0]          buttons_q;
	logic                buttons_changed_q;
	mera_pkg::acc16_t    delta_x_q;
	mera_pkg::acc16_t    delta_y_q;
	mera_pkg::acc16_t    wheel_steps_q;

	// handshake
	logic advance;
	logic fire_s1;
	logic accept;

	// result register empty or being drained: the input register may move on
	assign advance     = !result_valid_q || !result_stall;
	assign fire_s1     = valid_s1 && advance;
	assign event_stall = valid_s1 && !advance;
	assign accept      = event_valid && !event_stall;

	// event decode
	logic is_rel;
	logic is_key;
	logic is_sync_report;
	logic signed [32:0] value_ext;

	assign is_rel         = (type_s1 == mera_pkg::EV_TYPE_REL);
	assign is_key         = (type_s1 == mera_pkg::EV_TYPE_KEY);
	assign is_sync_report = (type_s1 == mera_pkg::EV_TYPE_SYNC)
		&& (code_s1 == mera_pkg::SYNC_CODE_REPORT);
	assign value_ext      = 33'(value_s1);

	// whole detents in the remainder, truncated toward zero
	logic                             rem_neg;
	logic [31:0]                      rem_mag;
	logic [mera_pkg::DETENT_PROD_W-1:0] div_prod;
	logic [31:0]                      quot_mag;
	logic [31:0]                      frac_mag;
	logic signed [32:0]               detent_steps;
	mera_pkg::acc32_t                 rem_after;

	always_comb begin
		rem_neg      = hires_rem_q[31];
		// magnitude of the most negative value is 2^31, still fits unsigned
		rem_mag      = rem_neg ? 32'(-hires_rem_q) : 32'(hires_rem_q);
		div_prod     = mera_pkg::DETENT_PROD_W'(rem_mag)
			* mera_pkg::DETENT_PROD_W'(mera_pkg::DETENT_MAGIC);
		quot_mag     = div_prod[mera_pkg::DETENT_SHIFT +: 32];
		frac_mag     = rem_mag - 32'(quot_mag * mera_pkg::DETENT_UNITS);
		detent_steps = rem_neg ? -$signed({1'b0, quot_mag}) : $signed({1'b0, quot_mag});
		rem_after    = rem_neg ? -$signed(frac_mag) : $signed(frac_mag);
	end

	// next state and result for the event in the input register
	logic [2:0]          mask_next;
	mera_pkg::acc16_t    accum_x_next;
	mera_pkg::acc16_t    accum_y_next;
	mera_pkg::acc16_t    accum_wheel_next;
	mera_pkg::acc32_t    hires_rem_next;
	logic                dirty_next;
	logic                rpt_valid;
	logic                btn_changed;
	mera_pkg::acc16_t    rpt_x;
	mera_pkg::acc16_t    rpt_y;
	mera_pkg::acc16_t    rpt_wheel;
	logic [2:0]          key_bit;

	always_comb begin
		mask_next        = button_mask_q;
		accum_x_next     = accum_x_q;
		accum_y_next     = accum_y_q;
		accum_wheel_next = accum_wheel_q;
		hires_rem_next   = hires_rem_q;
		dirty_next       = dirty_q;
		rpt_valid        = 1'b0;
		btn_changed      = 1'b0;
		rpt_x            = '0;
		rpt_y            = '0;
		rpt_wheel        = '0;
		key_bit          = 3'h0;

		unique case (code_s1)
			mera_pkg::KEY_CODE_LEFT:   key_bit = mera_pkg::MASK_BIT_LEFT;
			mera_pkg::KEY_CODE_RIGHT:  key_bit = mera_pkg::MASK_BIT_RIGHT;
			mera_pkg::KEY_CODE_MIDDLE: key_bit = mera_pkg::MASK_BIT_MIDDLE;
			default:                   key_bit = 3'h0;
		endcase

		if (is_rel) begin
			unique case (code_s1)
				mera_pkg::REL_CODE_X: begin
					accum_x_next = mera_pkg::sat_add16(accum_x_q, value_ext);
					dirty_next   = 1'b1;
				end
				mera_pkg::REL_CODE_Y: begin
					accum_y_next = mera_pkg::sat_add16(accum_y_q, value_ext);
					dirty_next   = 1'b1;
				end
				mera_pkg::REL_CODE_WHEEL: begin
					accum_wheel_next = mera_pkg::sat_add16(accum_wheel_q, value_ext);
					dirty_next       = 1'b1;
				end
				mera_pkg::REL_CODE_WHEEL_HIRES: begin
					// high-res alone never marks the report dirty
					hires_rem_next = mera_pkg::sat_add32(hires_rem_q, value_s1);
				end
				default: begin
				end
			endcase
		end else if (is_key) begin
			if (key_bit != 3'h0) begin
				mask_next = (value_s1 != 32'sd0) ? (button_mask_q | key_bit)
					: (button_mask_q & ~key_bit);
				if (mask_next != button_mask_q) begin
					btn_changed = 1'b1;
					dirty_next  = 1'b1;
				end
			end
		end else if (is_sync_report) begin
			// move whole detents into the wheel first
			if (quot_mag != 32'd0) begin
				accum_wheel_next = mera_pkg::sat_add16(accum_wheel_q, detent_steps);
				hires_rem_next   = rem_after;
				dirty_next       = 1'b1;
			end
			if (dirty_next) begin
				rpt_valid        = 1'b1;
				rpt_x            = accum_x_next;
				rpt_y            = accum_y_next;
				rpt_wheel        = accum_wheel_next;
				accum_x_next     = '0;
				accum_y_next     = '0;
				accum_wheel_next = '0;
				dirty_next       = 1'b0;
			end
		end
	end

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			button_mask_q  <= '0;
			accum_x_q      <= '0;
			accum_y_q      <= '0;
			accum_wheel_q  <= '0;
			hires_rem_q    <= '0;
			dirty_q        <= 1'b0;
		end else begin
			if (!valid_s1 || advance) begin
				valid_s1 <= event_valid;
			end
			if (advance) begin
				result_valid_q <= valid_s1;
			end
			if (fire_s1) begin
				button_mask_q <= mask_next;
				accum_x_q     <= accum_x_next;
				accum_y_q     <= accum_y_next;
				accum_wheel_q <= accum_wheel_next;
				hires_rem_q   <= hires_rem_next;
				dirty_q       <= dirty_next;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1  <= event_type;
			code_s1  <= event_code;
			value_s1 <= event_value;
		end
		if (fire_s1) begin
			report_valid_q    <= rpt_valid;
			buttons_q         <= mask_next;
			buttons_changed_q <= btn_changed;
			delta_x_q         <= rpt_x;
			delta_y_q         <= rpt_y;
			wheel_steps_q     <= rpt_wheel;
		end
	end

	assign result_valid    = result_valid_q;
	assign report_valid    = report_valid_q;
	assign buttons         = buttons_q;
	assign buttons_changed = buttons_changed_q;
	assign delta_x         = delta_x_q;
	assign delta_y         = delta_y_q;
	assign wheel_steps     = wheel_steps_q;

	// no report means all deltas are zero
	`MERA_ASSERT_NOW(a_idle_deltas_zero, clk, arst_n,
		result_valid && !report_valid,
		delta_x == 16'sd0 && delta_y == 16'sd0 && wheel_steps == 16'sd0)

	// only key events move the button mask
	`MERA_ASSERT_NEXT(a_mask_only_on_key, clk, arst_n,
		fire_s1 && !is_key, $stable(button_mask_q))

	// a report clears the accumulators and the dirty flag
	`MERA_ASSERT_NEXT(a_report_clears, clk, arst_n,
		fire_s1 && rpt_valid,
		!dirty_q && accum_x_q == 16'sd0 && accum_y_q == 16'sd0 && accum_wheel_q == 16'sd0)

	// after a sync report less than one detent stays in the remainder
	`MERA_ASSERT_NEXT(a_rem_below_detent, clk, arst_n,
		fire_s1 && is_sync_report,
		hires_rem_q < $signed(mera_pkg::DETENT_UNITS)
			&& hires_rem_q > -$signed(mera_pkg::DETENT_UNITS))

	// the input side stalls only with an item held in the input register
	`MERA_ASSERT_NOW(a_stall_needs_item, clk, arst_n,
		event_stall, valid_s1 && result_valid_q)

endmodule

// ----- tb/sv/mouse_event_report_accumulator_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for mouse_event_report_accumulator: a scoreboard class
// predicts one report per event item, a task drives events, an initial block the result stall
// depends on mera_pkg and the mouse_event_report_accumulator rtl
module mouse_event_report_accumulator_tb;

	// codes the block must ignore, used for near-miss stimulus
	localparam logic [15:0] EV_TYPE_UNKNOWN  = 16'hffff;
	localparam logic [15:0] REL_CODE_HWHEEL  = 16'h0006;
	localparam logic [15:0] KEY_CODE_SIDE    = 16'h0113;
	localparam logic [15:0] SYNC_CODE_CONFIG = 16'h0001;

	// mouse report as it leaves the result port
	typedef struct packed {
		logic               report_valid;
		logic [2:0]         buttons;
		logic               buttons_changed;
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic signed [15:0] wheel_steps;
	} mouse_report_t;

	// predicts the report for every accepted event and checks arriving reports in order
	class report_predictor;
		logic [2:0]         button_mask;
		logic signed [15:0] acc_x;
		logic signed [15:0] acc_y;
		logic signed [15:0] acc_wheel;
		logic signed [31:0] hires_rem;
		bit                 dirty;
		// newest report at the front, oldest at the back
		mouse_report_t      expected_reports[$];
		int unsigned        error_count;

		function new();
			button_mask = '0;
			acc_x       = '0;
			acc_y       = '0;
			acc_wheel   = '0;
			hires_rem   = '0;
			dirty       = 1'b0;
			error_count = 0;
		endfunction

		// 16-bit signed saturating accumulate
		function logic signed [15:0] add_sat16(logic signed [15:0] acc, longint val);
			longint sum;
			sum = longint'(acc) + val;
			if (sum > longint'(16'sh7fff)) begin
				return 16'sh7fff;
			end else if (sum < longint'(16'sh8000)) begin
				return 16'sh8000;
			end
			return 16'(sum);
		endfunction

		function void note_event(logic [15:0] ev_type, logic [15:0] ev_code,
			logic signed [31:0] ev_value);
			mouse_report_t rep;
			logic [2:0]    btn_bit;
			logic [2:0]    prev_mask;
			longint        sum;
			longint        steps;
			rep = '0;
			if (ev_type == mera_pkg::EV_TYPE_REL) begin
				if (ev_code == mera_pkg::REL_CODE_X) begin
					acc_x = add_sat16(acc_x, longint'(ev_value));
					dirty = 1'b1;
				end else if (ev_code == mera_pkg::REL_CODE_Y) begin
					acc_y = add_sat16(acc_y, longint'(ev_value));
					dirty = 1'b1;
				end else if (ev_code == mera_pkg::REL_CODE_WHEEL) begin
					acc_wheel = add_sat16(acc_wheel, longint'(ev_value));
					dirty = 1'b1;
				end else if (ev_code == mera_pkg::REL_CODE_WHEEL_HIRES) begin
					// remainder saturates at 32 bits and never marks dirty by itself
					sum = longint'(hires_rem) + longint'(ev_value);
					if (sum > longint'(32'sh7fff_ffff)) begin
						sum = longint'(32'sh7fff_ffff);
					end else if (sum < longint'(32'sh8000_0000)) begin
						sum = longint'(32'sh8000_0000);
					end
					hires_rem = 32'(sum);
				end
			end else if (ev_type == mera_pkg::EV_TYPE_KEY) begin
				btn_bit = '0;
				if (ev_code == mera_pkg::KEY_CODE_LEFT) begin
					btn_bit = mera_pkg::MASK_BIT_LEFT;
				end else if (ev_code == mera_pkg::KEY_CODE_RIGHT) begin
					btn_bit = mera_pkg::MASK_BIT_RIGHT;
				end else if (ev_code == mera_pkg::KEY_CODE_MIDDLE) begin
					btn_bit = mera_pkg::MASK_BIT_MIDDLE;
				end
				if (btn_bit != '0) begin
					prev_mask = button_mask;
					if (ev_value != 0) begin
						button_mask = button_mask | btn_bit;
					end else begin
						button_mask = button_mask & ~btn_bit;
					end
					if (prev_mask != button_mask) begin
						rep.buttons_changed = 1'b1;
						dirty = 1'b1;
					end
				end
			end else if (ev_type == mera_pkg::EV_TYPE_SYNC
				&& ev_code == mera_pkg::SYNC_CODE_REPORT) begin
				// whole detents move out of the remainder, truncating toward zero
				steps = longint'(hires_rem) / longint'(mera_pkg::UNITS_PER_DETENT);
				if (steps != 0) begin
					acc_wheel = add_sat16(acc_wheel, steps);
					hires_rem = 32'(longint'(hires_rem)
						- steps * longint'(mera_pkg::UNITS_PER_DETENT));
					dirty = 1'b1;
				end
				if (dirty) begin
					rep.report_valid = 1'b1;
					rep.delta_x      = acc_x;
					rep.delta_y      = acc_y;
					rep.wheel_steps  = acc_wheel;
					acc_x     = '0;
					acc_y     = '0;
					acc_wheel = '0;
					dirty     = 1'b0;
				end
			end
			rep.buttons = button_mask;
			expected_reports.push_front(rep);
		endfunction

		function void check_report(mouse_report_t got);
			mouse_report_t want;
			if (expected_reports.size() == 0) begin
				$error("result item with no expected report pending");
				error_count++;
				return;
			end
			want = expected_reports.pop_back();
			if (got.report_valid !== want.report_valid) begin
				$error("report_valid: expected %0d, actual %0d", want.report_valid,
					got.report_valid);
				error_count++;
			end
			if (got.buttons !== want.buttons) begin
				$error("buttons: expected %0d, actual %0d", want.buttons, got.buttons);
				error_count++;
			end
			if (got.buttons_changed !== want.buttons_changed) begin
				$error("buttons_changed: expected %0d, actual %0d", want.buttons_changed,
					got.buttons_changed);
				error_count++;
			end
			if (got.delta_x !== want.delta_x) begin
				$error("delta_x: expected %0d, actual %0d", want.delta_x, got.delta_x);
				error_count++;
			end
			if (got.delta_y !== want.delta_y) begin
				$error("delta_y: expected %0d, actual %0d", want.delta_y, got.delta_y);
				error_count++;
			end
			if (got.wheel_steps !== want.wheel_steps) begin
				$error("wheel_steps: expected %0d, actual %0d", want.wheel_steps,
					got.wheel_steps);
				error_count++;
			end
		endfunction

		function int unsigned pending();
			return expected_reports.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               event_valid;
	logic               event_stall;
	logic [15:0]        event_type;
	logic [15:0]        event_code;
	logic signed [31:0] event_value;
	logic               result_valid;
	logic               result_stall;
	logic               report_valid;
	logic [2:0]         buttons;
	logic               buttons_changed;
	logic signed [15:0] delta_x;
	logic signed [15:0] delta_y;
	logic signed [15:0] wheel_steps;

	report_predictor predictor = new();

	// when clear, both sides run back to back with no idle cycles
	bit idle_on = 1'b1;

	mouse_event_report_accumulator uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.event_valid     (event_valid),
		.event_stall     (event_stall),
		.event_type      (event_type),
		.event_code      (event_code),
		.event_value     (event_value),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.report_valid    (report_valid),
		.buttons         (buttons),
		.buttons_changed (buttons_changed),
		.delta_x         (delta_x),
		.delta_y         (delta_y),
		.wheel_steps     (wheel_steps)
	);

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("mouse_event_report_accumulator_tb: errors");
		$finish;
	end

	// present one event item after a random gap, hold it until taken, then predict
	task automatic send_event(input logic [15:0] ev_type, input logic [15:0] ev_code,
		input logic signed [31:0] ev_value);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, 16) : 0;
		if (gap != 0) begin
			event_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		event_valid <= 1'b1;
		event_type  <= ev_type;
		event_code  <= ev_code;
		event_value <= ev_value;
		// outputs read right after the edge still hold the values sampled at it
		do @(posedge clk); while (event_stall);
		predictor.note_event(ev_type, ev_code, ev_value);
	endtask

	// sender holds off until every expected report has come back
	task automatic drain_reports();
		event_valid <= 1'b0;
		do @(posedge clk); while (predictor.pending() != 0);
	endtask

	// mostly small movement, some mid-size to reach saturation, a few extremes
	function automatic logic signed [31:0] draw_event_value();
		case ($urandom_range(0, 9))
			0: begin
				return $urandom;
			end
			1: begin
				return 32'sh7fff_ffff;
			end
			2: begin
				return 32'sh8000_0000;
			end
			3, 4: begin
				return int'($urandom_range(0, 80000)) - 40000;
			end
			default: begin
				return int'($urandom_range(0, 600)) - 300;
			end
		endcase
	endfunction

	// one random item, including some that the block only ignores
	task automatic send_random_event();
		logic [15:0]        ev_type;
		logic [15:0]        ev_code;
		logic signed [31:0] ev_value;
		int unsigned        pick;
		int unsigned        sel;
		pick     = $urandom_range(0, 99);
		sel      = $urandom_range(0, 2);
		ev_type  = mera_pkg::EV_TYPE_SYNC;
		ev_code  = mera_pkg::SYNC_CODE_REPORT;
		ev_value = draw_event_value();
		if (pick < 24) begin
			// plain relative motion
			ev_type = mera_pkg::EV_TYPE_REL;
			ev_code = (sel == 0) ? mera_pkg::REL_CODE_X
				: (sel == 1) ? mera_pkg::REL_CODE_Y : mera_pkg::REL_CODE_WHEEL;
		end else if (pick < 38) begin
			// high-res wheel, mostly around a few detents so syncs move whole steps
			ev_type = mera_pkg::EV_TYPE_REL;
			ev_code = mera_pkg::REL_CODE_WHEEL_HIRES;
			if ($urandom_range(0, 3) != 0) begin
				ev_value = int'($urandom_range(0, 720)) - 360;
			end
		end else if (pick < 56) begin
			// button press or release, pressed values are any nonzero word
			ev_type = mera_pkg::EV_TYPE_KEY;
			ev_code = (sel == 0) ? mera_pkg::KEY_CODE_LEFT
				: (sel == 1) ? mera_pkg::KEY_CODE_RIGHT : mera_pkg::KEY_CODE_MIDDLE;
			if ($urandom_range(0, 2) == 0) begin
				ev_value = 0;
			end else if ($urandom_range(0, 1) == 0) begin
				ev_value = 1;
			end else begin
				ev_value = $urandom;
			end
		end else if (pick < 80) begin
			// sync report keeps its defaults, value is don't-care
		end else if (pick < 90) begin
			// pure noise over every bit of every field
			ev_type  = 16'($urandom);
			ev_code  = 16'($urandom);
			ev_value = $urandom;
		end else begin
			// known type with an arbitrary code
			ev_type = 16'($urandom_range(0, 2));
			ev_code = 16'($urandom);
		end
		send_event(ev_type, ev_code, ev_value);
	endtask

	// every accepted result goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			predictor.check_report({report_valid, buttons, buttons_changed, delta_x,
				delta_y, wheel_steps});
		end
	end

	// result side: random stall before each item, none while idling is off
	initial begin
		int unsigned hold;
		result_stall <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			hold = idle_on ? $urandom_range(0, 16) : 0;
			if (hold != 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				result_stall <= 1'b0;
			end
			do @(posedge clk); while (!result_valid);
		end
	end

	// reset, directed corners, then random traffic in phases
	initial begin
		int unsigned item_no;
		arst_n      <= 1'b0;
		event_valid <= 1'b0;
		event_type  <= '0;
		event_code  <= '0;
		event_value <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// x saturates high, y and wheel take the extreme 32-bit values
		send_event(mera_pkg::EV_TYPE_REL, mera_pkg::REL_CODE_X, 32'sd32767);
		send_event(mera_pkg::EV_TYPE_REL, mera_pkg::REL_CODE_X, 32'sd32767);
		send_event(mera_pkg::EV_TYPE_REL, mera_pkg::REL_CODE_Y, 32'sh8000_0000);
		send_event(mera_pkg::EV_TYPE_REL, mera_pkg::REL_CODE_WHEEL, 32'sh7fff_ffff);
		send_event(mera_pkg::EV_TYPE_SYNC, mera_pkg::SYNC_CODE_REPORT, 32'sd0);
		// high-res below one detent: sync has nothing to report
		send_event(mera_pkg::EV_TYPE_REL, mera_pkg::REL_CODE_WHEEL_HIRES, 32'sd119);
		send_event(mera_pkg::EV_TYPE_SYNC, mera_pkg::SYNC_CODE_REPORT, 32'sd0);
		// reaching one detent makes the sync report a step
		send_event(mera_pkg::EV_TYPE_REL, mera_pkg::REL_CODE_WHEEL_HIRES, 32'sd1);
		send_event(mera_pkg::EV_TYPE_SYNC, mera_pkg::SYNC_CODE_REPORT, 32'sd0);
		// remainder saturates low, detents saturate the wheel
		send_event(mera_pkg::EV_TYPE_REL, mera_pkg::REL_CODE_WHEEL_HIRES, 32'sh8000_0000);
		send_event(mera_pkg::EV_TYPE_REL, mera_pkg::REL_CODE_WHEEL_HIRES, 32'sh8000_0000);
		send_event(mera_pkg::EV_TYPE_SYNC, mera_pkg::SYNC_CODE_REPORT, 32'sd0);
		// buttons, including a repeated press that changes nothing
		send_event(mera_pkg::EV_TYPE_KEY, mera_pkg::KEY_CODE_LEFT, 32'sd1);
		send_event(mera_pkg::EV_TYPE_KEY, mera_pkg::KEY_CODE_LEFT, 32'sd5);
		send_event(mera_pkg::EV_TYPE_KEY, mera_pkg::KEY_CODE_RIGHT, -32'sd1);
		send_event(mera_pkg::EV_TYPE_KEY, mera_pkg::KEY_CODE_MIDDLE, 32'sh8000_0000);
		send_event(mera_pkg::EV_TYPE_KEY, mera_pkg::KEY_CODE_LEFT, 32'sd0);
		send_event(mera_pkg::EV_TYPE_SYNC, mera_pkg::SYNC_CODE_REPORT, 32'sd0);
		// ignored types and codes
		send_event(EV_TYPE_UNKNOWN, 16'hffff, -32'sd1);
		send_event(mera_pkg::EV_TYPE_REL, REL_CODE_HWHEEL, 32'sd3);
		send_event(mera_pkg::EV_TYPE_KEY, KEY_CODE_SIDE, 32'sd1);
		send_event(mera_pkg::EV_TYPE_SYNC, SYNC_CODE_CONFIG, 32'sd0);
		send_event(mera_pkg::EV_TYPE_SYNC, mera_pkg::SYNC_CODE_REPORT, 32'sd0);
		// a maximal high-res value onto the small negative leftover stays just short of saturation
		send_event(mera_pkg::EV_TYPE_REL, mera_pkg::REL_CODE_WHEEL_HIRES, 32'sh7fff_ffff);
		send_event(mera_pkg::EV_TYPE_SYNC, mera_pkg::SYNC_CODE_REPORT, 32'sd0);
		drain_reports();

		item_no = 0;
		while (item_no < 1000) begin
			// new phase every 64 items: idling on most of the time, off in between
			if (item_no % 64 == 0) begin
				idle_on = ($urandom_range(0, 3) != 0);
			end
			if (item_no % 250 == 249) begin
				drain_reports();
			end
			send_random_event();
			item_no++;
		end

		// wait out the pipeline, bounded by the timeout above
		event_valid <= 1'b0;
		do @(posedge clk); while (predictor.pending() != 0);
		repeat (8) @(posedge clk);
		if (predictor.error_count == 0 && predictor.pending() == 0) begin
			$display("mouse_event_report_accumulator_tb: clean");
		end else begin
			$display("mouse_event_report_accumulator_tb: errors");
		end
		$finish;
	end

endmodule
